FILE: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types, codes and microprogram of the rational unit
// Holds the operation codes, the control word layout, the sequencer
// condition bundle and the read-only microprogram table.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Default operand width of the fraction inputs.
  localparam int DEFAULT_OPERAND_WIDTH = 16;

  // Operation codes carried by the op field.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Width of the microprogram step counter.
  localparam int PC_W = 4;

  // Step addresses of the microprogram.
  localparam logic [PC_W-1:0] STEP_MUL_P    = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL_Q    = 4'd1;
  localparam logic [PC_W-1:0] STEP_MUL_D    = 4'd2;
  localparam logic [PC_W-1:0] STEP_COMBINE  = 4'd3;
  localparam logic [PC_W-1:0] STEP_GCD_INIT = 4'd4;
  localparam logic [PC_W-1:0] STEP_GCD_LOOP = 4'd5;
  localparam logic [PC_W-1:0] STEP_DIV_INIT = 4'd6;
  localparam logic [PC_W-1:0] STEP_DIV_LOOP = 4'd7;
  localparam logic [PC_W-1:0] STEP_FIN_OK   = 4'd8;
  localparam logic [PC_W-1:0] STEP_FIN_ERR  = 4'd9;
  localparam logic [PC_W-1:0] STEP_FIN_ZERO = 4'd10;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_MUL_P,
    ALU_MUL_Q,
    ALU_MUL_D,
    ALU_COMBINE,
    ALU_GCD_INIT,
    ALU_GCD_STEP,
    ALU_DIV_INIT,
    ALU_DIV_STEP
  } alu_op_t;

  // Jump condition of a control word; a taken jump loads the target step.
  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_DEN_ZERO,
    JMP_MAG_ZERO,
    JMP_GCD_BUSY,
    JMP_DIV_BUSY
  } jump_t;

  // Result written when the program ends.
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_OK,
    FIN_ERR,
    FIN_ZERO
  } fin_t;

  typedef struct packed {
    alu_op_t         alu;
    jump_t           jmp;
    logic [PC_W-1:0] target;
    fin_t            fin;
  } ctrl_t;

  // Status flags from the datapath that steer the sequencer.
  typedef struct packed {
    logic den_zero;
    logic mag_zero;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } cond_t;

  // Microprogram table: one control word per step.
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] addr);
    ctrl_t w;
    w = '{alu: ALU_NOP, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_ERR};
    unique case (addr)
      STEP_MUL_P:    w = '{alu: ALU_MUL_P, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_NONE};
      STEP_MUL_Q:    w = '{alu: ALU_MUL_Q, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_NONE};
      STEP_MUL_D:    w = '{alu: ALU_MUL_D, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_NONE};
      STEP_COMBINE:  w = '{alu: ALU_COMBINE, jmp: JMP_DEN_ZERO, target: STEP_FIN_ERR,
                           fin: FIN_NONE};
      STEP_GCD_INIT: w = '{alu: ALU_GCD_INIT, jmp: JMP_MAG_ZERO, target: STEP_FIN_ZERO,
                           fin: FIN_NONE};
      STEP_GCD_LOOP: w = '{alu: ALU_GCD_STEP, jmp: JMP_GCD_BUSY, target: STEP_GCD_LOOP,
                           fin: FIN_NONE};
      STEP_DIV_INIT: w = '{alu: ALU_DIV_INIT, jmp: JMP_NONE, target: STEP_MUL_P,
                           fin: FIN_NONE};
      STEP_DIV_LOOP: w = '{alu: ALU_DIV_STEP, jmp: JMP_DIV_BUSY, target: STEP_DIV_LOOP,
                           fin: FIN_NONE};
      STEP_FIN_OK:   w = '{alu: ALU_NOP, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_OK};
      STEP_FIN_ERR:  w = '{alu: ALU_NOP, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_ERR};
      STEP_FIN_ZERO: w = '{alu: ALU_NOP, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_ZERO};
      default:       w = '{alu: ALU_NOP, jmp: JMP_NONE, target: STEP_MUL_P, fin: FIN_ERR};
    endcase
    return w;
  endfunction

endpackage

FILE: design/rau_seq.sv
// ----------------------------------------------------------------------------
// rau_seq: microprogram sequencer of the rational unit
// Step counter over the read-only microprogram, with conditional jumps on
// datapath flags and a hold on the final step while the output is full.
// ----------------------------------------------------------------------------
module rau_seq
  import rau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  cond_t cond,
  output logic  busy,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy_next;
  logic            taken;

  // Fetch the control word of the current step.
  assign ctrl = ucode_rom(pc);

  // Evaluate the jump condition of the current word.
  always_comb begin
    unique case (ctrl.jmp)
      JMP_NONE:     taken = 1'b0;
      JMP_DEN_ZERO: taken = cond.den_zero;
      JMP_MAG_ZERO: taken = cond.mag_zero;
      JMP_GCD_BUSY: taken = !cond.gcd_done;
      JMP_DIV_BUSY: taken = !cond.div_last;
      default:      taken = 1'b0;
    endcase
  end

  // Next step: start on an accepted item, end on a finish word once the
  // output register is free, otherwise jump or fall through.
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        pc_next   = STEP_MUL_P;
      end
    end else if (ctrl.fin != FIN_NONE) begin
      if (cond.out_free) begin
        busy_next = 1'b0;
      end
    end else if (taken) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= STEP_MUL_P;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

endmodule

FILE: design/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit: add, subtract, multiply or divide two fractions
// Forms the cross products on one shared multiplier, reduces the result by
// its greatest common divisor and returns the fraction in lowest terms with
// the sign on the numerator.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  op, a_num, a_den, b_num, b_den
//   out      out_valid/ out_ready res_num, res_den, status
//
// The time an item takes is set by the binary GCD subtract loop and the
// one-bit-per-cycle quotient loop. A zero denominator ends with an error
// and a zero numerator with a zero result, both without the loops. One
// item is in work at a time; the next is taken as soon as the previous
// result sits in the output register. A result waiting on out_ready holds
// the final step. Reset is synchronous.
// ----------------------------------------------------------------------------
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic signed [OPERAND_WIDTH-1:0]  a_num,
  input  logic [OPERAND_WIDTH-1:0]         a_den,
  input  logic signed [OPERAND_WIDTH-1:0]  b_num,
  input  logic [OPERAND_WIDTH-1:0]         b_den,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [2*OPERAND_WIDTH:0]  res_num,
  output logic [2*OPERAND_WIDTH-1:0]       res_den,
  output logic                             status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int N  = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(N);

  // Operand registers.
  logic [1:0]    op_r;
  logic          an;
  logic          bn;
  logic [W-1:0]  am;
  logic [W-1:0]  bm;
  logic [W-1:0]  ad;
  logic [W-1:0]  bd;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;

  // Products and working registers.
  logic [N-1:0]  p;
  logic [N-1:0]  q;
  logic [N-1:0]  den;
  logic [N-1:0]  rmag;
  logic          rneg;
  logic [N-1:0]  u;
  logic [N-1:0]  v;
  logic [N-1:0]  nr;
  logic [N-1:0]  dr;
  logic [N-1:0]  rem_n;
  logic [N-1:0]  rem_d;
  logic [CW-1:0] cnt;

  // Control.
  logic          busy;
  logic          accept;
  logic          fin_fire;
  ctrl_t         ctrl;
  cond_t         cond;

  // Shared multiplier.
  logic [W-1:0]  mul_x;
  logic [W-1:0]  mul_y;
  logic [N-1:0]  product;

  // Sign combine.
  logic          q_neg;
  logic [N-1:0]  comb_mag;
  logic          comb_neg;

  // GCD step.
  logic          u_gt_v;
  logic [N-1:0]  diff;
  logic          gcd_done;

  // Quotient step.
  logic [N:0]    sh_n;
  logic [N:0]    sh_d;
  logic          ge_n;
  logic          ge_d;
  logic [N:0]    sub_n;
  logic [N:0]    sub_d;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  // Sign and magnitude of the incoming numerators.
  assign a_mag = a_num[W-1] ? (~$unsigned(a_num)) + 1'b1 : $unsigned(a_num);
  assign b_mag = b_num[W-1] ? (~$unsigned(b_num)) + 1'b1 : $unsigned(b_num);

  // Sequencer flags.
  assign gcd_done      = u[0] && v[0] && (u == v);
  assign cond.den_zero = (den == '0);
  assign cond.mag_zero = (rmag == '0);
  assign cond.gcd_done = gcd_done;
  assign cond.div_last = (cnt == CW'(N - 1));
  assign cond.out_free = !out_valid || out_ready;

  rau_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .cond  (cond),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctrl.alu)
      ALU_MUL_P: begin
        mul_x = am;
        mul_y = (op_r == OP_MUL) ? bm : bd;
      end
      ALU_MUL_Q: begin
        mul_x = bm;
        mul_y = ad;
      end
      ALU_MUL_D: begin
        mul_x = ad;
        mul_y = (op_r == OP_DIV) ? bm : bd;
      end
      default: begin
        mul_x = am;
        mul_y = bd;
      end
    endcase
  end

  assign product = N'(mul_x) * N'(mul_y);

  // Signed sum, difference or product (MUL, DIV); a zero q term is positive.
  always_comb begin
    q_neg = ((op_r == OP_SUB) ? !bn : bn) && (q != '0);
    if ((op_r == OP_MUL) || (op_r == OP_DIV)) begin
      comb_mag = p;
      comb_neg = an ^ bn;
    end else if (an == q_neg) begin
      comb_mag = p + q;
      comb_neg = an;
    end else if (p >= q) begin
      comb_mag = p - q;
      comb_neg = an;
    end else begin
      comb_mag = q - p;
      comb_neg = q_neg;
    end
  end

  // Difference of the two odd GCD operands.
  assign u_gt_v = u > v;
  assign diff   = u_gt_v ? (u - v) : (v - u);

  // Restoring quotient step for numerator and denominator by the odd GCD.
  assign sh_n  = {rem_n, nr[N-1]};
  assign sh_d  = {rem_d, dr[N-1]};
  assign ge_n  = sh_n >= {1'b0, u};
  assign ge_d  = sh_d >= {1'b0, u};
  assign sub_n = sh_n - {1'b0, u};
  assign sub_d = sh_d - {1'b0, u};

  // Datapath registers driven by the current control word.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op;
      an   <= a_num[W-1];
      bn   <= b_num[W-1];
      am   <= a_mag;
      bm   <= b_mag;
      ad   <= a_den;
      bd   <= b_den;
    end else if (busy) begin
      case (ctrl.alu)
        ALU_MUL_P: p   <= product;
        ALU_MUL_Q: q   <= product;
        ALU_MUL_D: den <= product;
        ALU_COMBINE: begin
          rmag <= comb_mag;
          rneg <= comb_neg;
        end
        ALU_GCD_INIT: begin
          u  <= rmag;
          v  <= den;
          nr <= rmag;
          dr <= den;
        end
        ALU_GCD_STEP: begin
          // Common factors of two leave the originals with the operands.
          if (!u[0] && !v[0]) begin
            u  <= u >> 1;
            v  <= v >> 1;
            nr <= nr >> 1;
            dr <= dr >> 1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (!gcd_done) begin
            if (u_gt_v) begin
              u <= diff >> 1;
            end else begin
              v <= diff >> 1;
            end
          end
        end
        ALU_DIV_INIT: begin
          rem_n <= '0;
          rem_d <= '0;
          cnt   <= '0;
        end
        ALU_DIV_STEP: begin
          rem_n <= ge_n ? sub_n[N-1:0] : sh_n[N-1:0];
          rem_d <= ge_d ? sub_d[N-1:0] : sh_d[N-1:0];
          nr    <= {nr[N-2:0], ge_n};
          dr    <= {dr[N-2:0], ge_d};
          cnt   <= cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register; the finish step writes it once it is free.
  assign fin_fire = busy && (ctrl.fin != FIN_NONE) && cond.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      case (ctrl.fin)
        FIN_OK: begin
          res_num <= rneg ? $signed(~{1'b0, nr} + 1'b1) : $signed({1'b0, nr});
          res_den <= dr;
          status  <= 1'b0;
        end
        FIN_ZERO: begin
          res_num <= '0;
          res_den <= N'(1);
          status  <= 1'b0;
        end
        default: begin
          res_num <= '0;
          res_den <= '0;
          status  <= 1'b1;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted item starts the program on the next cycle.
  a_start: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted item did not start the sequencer");

  // The GCD loop only runs on nonzero operands.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy && (ctrl.alu == ALU_GCD_STEP) |-> (u != '0) && (v != '0))
    else $error("GCD step on a zero operand");

  // Partial remainders stay below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy && (ctrl.alu == ALU_DIV_STEP) |-> (rem_n < u) && (rem_d < u))
    else $error("quotient remainder out of range");

  // An error result carries a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (res_den == '0) && (res_num == '0))
    else $error("error result with nonzero fraction");

  // A good result always has a positive denominator.
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> (res_den != '0))
    else $error("good result with zero denominator");
`endif

endmodule
